@@ rtl/msp_frame_parser_core_defines.svh @@
// Assertion macros shared by the MSP frame parser checkers.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef MSP_FRAME_PARSER_CORE_DEFINES_SVH
`define MSP_FRAME_PARSER_CORE_DEFINES_SVH

// Checked only while out of reset.
`define MSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define MSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/msp_pkg.sv @@
// Package for the MSP frame parser: parser states, event codes, result record,
// character constants and the CRC-8 (poly 0xD5) byte step. No dependencies.
package msp_pkg;

  localparam logic [7:0] CH_DOLLAR       = 8'h24;
  localparam logic [7:0] CH_M            = 8'h4D;
  localparam logic [7:0] CH_X            = 8'h58;
  localparam logic [7:0] CMD_V2_TUNNEL   = 8'hFF;
  localparam logic [7:0] MIN_TUNNEL_SIZE = 8'd6;
  localparam logic [7:0] CRC_POLY        = 8'hD5;
  localparam logic [7:0] MAX_PAYLOAD_RST = 8'd192;
  localparam logic [7:0] DIR_CHAR_RST    = 8'h3E;

  localparam int unsigned HDR_DEPTH = 7;
  localparam int unsigned HDR_AW    = $clog2(HDR_DEPTH);

  localparam logic [7:0] CFG_MAX_PAYLOAD = 8'd0;
  localparam logic [7:0] CFG_DIR_CHAR    = 8'd1;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'd0,
    ST_START   = 4'd1,
    ST_M       = 4'd2,
    ST_X       = 4'd3,
    ST_HDR_V1  = 4'd4,
    ST_PAY_V1  = 4'd5,
    ST_CK_V1   = 4'd6,
    ST_HDR_V21 = 4'd7,
    ST_PAY_V21 = 4'd8,
    ST_CK_V21  = 4'd9,
    ST_HDR_V2N = 4'd10,
    ST_PAY_V2N = 4'd11,
    ST_CK_V2N  = 4'd12
  } state_e;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_GOOD    = 3'd2,
    EV_CKSUM   = 3'd3,
    EV_SIZE    = 3'd4,
    EV_ABANDON = 3'd5
  } event_e;

  localparam logic [1:0] VER_V1  = 2'd0;
  localparam logic [1:0] VER_V21 = 2'd1;
  localparam logic [1:0] VER_V2N = 2'd2;

  typedef struct packed {
    logic        accepted;
    event_e      ev;
    logic [7:0]  pbyte;
    logic [7:0]  pidx;
    logic [1:0]  version;
    logic [15:0] command;
    logic [7:0]  flags;
    logic [7:0]  size;
  } res_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    end
    return v;
  endfunction

endpackage

@@ rtl/msp_frame_parser_core.sv @@
// MSP frame parser, top level: configuration registers, request handshakes and
// the result register around msp_parse. Depends on msp_pkg and msp_parse.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, byte_in_i) carries one received
//   serial byte per request. Every byte yields exactly one result on the
//   output channel (out_valid_o/out_ready_i): accepted flag, event code,
//   payload byte and index, and frame version/command/flags/size on a good
//   frame or checksum error.
//   Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i):
//   index 0 max_payload, index 1 direction_char; other indexes are ignored.
//   cfg_ready_o is always high; write only while the parser is idle.
//   Result timing: registered, valid in the cycle after input accept.
//   Throughput: one byte per cycle while results are taken; the parser step is
//   a single pass of logic from the state registers into the result register.
//   Reset: parser idle, max_payload 192, direction_char '>', no result held.
//   Stall: a held result keeps in_ready_o low until it is taken; the taking
//   cycle can accept the next byte.
module msp_frame_parser_core
  import msp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [2:0]  event_res_o,
  output logic [7:0]  payload_byte_o,
  output logic [7:0]  payload_index_o,
  output logic [1:0]  frame_version_o,
  output logic [15:0] command_o,
  output logic [7:0]  frame_flags_o,
  output logic [7:0]  payload_size_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic [7:0] max_payload_q;
  logic [7:0] dir_char_q;
  logic       out_valid_q, out_valid_d;
  res_t       res_q, res_d;
  logic       in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  msp_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_fire),
    .byte_i        (byte_in_i),
    .max_payload_i (max_payload_q),
    .dir_char_i    (dir_char_q),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RST;
      dir_char_q    <= DIR_CHAR_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_MAX_PAYLOAD) max_payload_q <= cfg_data_i;
      if (cfg_index_i == CFG_DIR_CHAR)    dir_char_q    <= cfg_data_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) res_q <= res_d;
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = res_q.accepted;
  assign event_res_o     = res_q.ev;
  assign payload_byte_o  = res_q.pbyte;
  assign payload_index_o = res_q.pidx;
  assign frame_version_o = res_q.version;
  assign command_o       = res_q.command;
  assign frame_flags_o   = res_q.flags;
  assign payload_size_o  = res_q.size;

endmodule

@@ rtl/msp_parse.sv @@
// MSP deframing state machine: parser state, running checksums and header store,
// plus the per-byte next-state and result logic. Depends on msp_pkg.
module msp_parse
  import msp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] max_payload_i,
  input  logic [7:0] dir_char_i,
  output res_t       res_o
);

  state_e      state_q, state_d;
  logic [7:0]  offset_q, offset_d;
  logic [7:0]  size_q, size_d;
  logic [1:0]  ver_q, ver_d;
  logic [15:0] cmd_q, cmd_d;
  logic [7:0]  flags_q, flags_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  hdr_q [HDR_DEPTH];
  logic        hdr_we;
  logic [7:0]  crc_nx;
  event_e      ev;

  assign crc_nx = crc8_step(crc_q, byte_i);

  always_comb begin
    state_d  = state_q;
    offset_d = offset_q;
    size_d   = size_q;
    ver_d    = ver_q;
    cmd_d    = cmd_q;
    flags_d  = flags_q;
    xor_d    = xor_q;
    crc_d    = crc_q;
    hdr_we   = 1'b0;
    ev       = EV_NONE;
    res_o    = '0;
    res_o.accepted = 1'b1;

    unique case (state_q)
      ST_START: begin
        if (byte_i == CH_M) state_d = ST_M;
        else if (byte_i == CH_X) state_d = ST_X;
        else begin
          state_d = ST_IDLE;
          ev      = EV_ABANDON;
        end
      end
      ST_M: begin
        if (byte_i == dir_char_i) begin
          offset_d = '0;
          xor_d    = '0;
          crc_d    = '0;
          state_d  = ST_HDR_V1;
        end else begin
          state_d = ST_IDLE;
          ev      = EV_ABANDON;
        end
      end
      ST_X: begin
        if (byte_i == dir_char_i) begin
          offset_d = '0;
          crc_d    = '0;
          ver_d    = VER_V2N;
          state_d  = ST_HDR_V2N;
        end else begin
          state_d = ST_IDLE;
          ev      = EV_ABANDON;
        end
      end
      ST_HDR_V1: begin
        hdr_we   = (offset_q < 8'(HDR_DEPTH));
        offset_d = offset_q + 8'd1;
        xor_d    = xor_q ^ byte_i;
        if (offset_q >= 8'd1) begin
          // size is header byte 0, command is the byte at hand
          if (hdr_q[0] > max_payload_i) begin
            state_d = ST_IDLE;
            ev      = EV_SIZE;
          end else if (byte_i == CMD_V2_TUNNEL) begin
            if (hdr_q[0] >= MIN_TUNNEL_SIZE) begin
              ver_d   = VER_V21;
              state_d = ST_HDR_V21;
            end else begin
              state_d = ST_IDLE;
              ev      = EV_ABANDON;
            end
          end else begin
            size_d   = hdr_q[0];
            cmd_d    = {8'd0, byte_i};
            flags_d  = '0;
            offset_d = '0;
            state_d  = (hdr_q[0] != 8'd0) ? ST_PAY_V1 : ST_CK_V1;
          end
        end
      end
      ST_PAY_V1, ST_PAY_V21, ST_PAY_V2N: begin
        ev           = EV_PAYLOAD;
        res_o.pbyte  = byte_i;
        res_o.pidx   = offset_q;
        if (state_q != ST_PAY_V2N) xor_d = xor_q ^ byte_i;
        if (state_q != ST_PAY_V1) crc_d = crc_nx;
        offset_d = offset_q + 8'd1;
        if (offset_q + 8'd1 == size_q) begin
          unique case (state_q)
            ST_PAY_V1:  state_d = ST_CK_V1;
            ST_PAY_V21: state_d = ST_CK_V21;
            default:    state_d = ST_CK_V2N;
          endcase
        end
      end
      ST_CK_V1, ST_CK_V2N: begin
        ev      = (((state_q == ST_CK_V1) ? xor_q : crc_q) == byte_i) ? EV_GOOD : EV_CKSUM;
        state_d = ST_IDLE;
      end
      ST_HDR_V21: begin
        hdr_we   = (offset_q < 8'(HDR_DEPTH));
        offset_d = offset_q + 8'd1;
        xor_d    = xor_q ^ byte_i;
        crc_d    = crc_nx;
        if (offset_q >= 8'd6) begin
          // flags at 2, command at 3..4, size at 5 and the byte at hand
          if (byte_i != 8'd0 || hdr_q[5] > max_payload_i) begin
            state_d = ST_IDLE;
            ev      = EV_SIZE;
          end else begin
            size_d   = hdr_q[5];
            cmd_d    = {hdr_q[4], hdr_q[3]};
            flags_d  = hdr_q[2];
            offset_d = '0;
            state_d  = (hdr_q[5] != 8'd0) ? ST_PAY_V21 : ST_CK_V21;
          end
        end
      end
      ST_CK_V21: begin
        xor_d = xor_q ^ byte_i;
        if (crc_q == byte_i) state_d = ST_CK_V1;
        else begin
          state_d = ST_IDLE;
          ev      = EV_CKSUM;
        end
      end
      ST_HDR_V2N: begin
        hdr_we   = (offset_q < 8'(HDR_DEPTH));
        offset_d = offset_q + 8'd1;
        crc_d    = crc_nx;
        if (offset_q >= 8'd4) begin
          // flags at 0, command at 1..2, size at 3 and the byte at hand
          if (byte_i != 8'd0 || hdr_q[3] > max_payload_i) begin
            state_d = ST_IDLE;
            ev      = EV_SIZE;
          end else begin
            size_d   = hdr_q[3];
            cmd_d    = {hdr_q[2], hdr_q[1]};
            flags_d  = hdr_q[0];
            offset_d = '0;
            state_d  = (hdr_q[3] != 8'd0) ? ST_PAY_V2N : ST_CK_V2N;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
        if (byte_i == CH_DOLLAR) begin
          ver_d   = VER_V1;
          state_d = ST_START;
        end else begin
          res_o.accepted = 1'b0;
        end
      end
    endcase

    res_o.ev = ev;
    if (ev == EV_GOOD || ev == EV_CKSUM) begin
      res_o.version = ver_q;
      res_o.command = cmd_q;
      res_o.flags   = flags_q;
      res_o.size    = size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      offset_q <= '0;
      size_q   <= '0;
      ver_q    <= '0;
      cmd_q    <= '0;
      flags_q  <= '0;
      xor_q    <= '0;
      crc_q    <= '0;
    end else if (step_i) begin
      state_q  <= state_d;
      offset_q <= offset_d;
      size_q   <= size_d;
      ver_q    <= ver_d;
      cmd_q    <= cmd_d;
      flags_q  <= flags_d;
      xor_q    <= xor_d;
      crc_q    <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && hdr_we) begin
      hdr_q[offset_q[HDR_AW-1:0]] <= byte_i;
    end
  end

endmodule

@@ rtl/msp_frame_parser_core_chk.sv @@
// Port-level checker for msp_frame_parser_core, bound to the top level.
// Depends on msp_pkg and msp_frame_parser_core_defines.svh.
`include "msp_frame_parser_core_defines.svh"

module msp_frame_parser_core_chk
  import msp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        accepted_o,
  input logic [2:0]  event_res_o,
  input logic [7:0]  payload_byte_o,
  input logic [7:0]  payload_index_o,
  input logic [1:0]  frame_version_o,
  input logic [15:0] command_o,
  input logic [7:0]  frame_flags_o,
  input logic [7:0]  payload_size_o
);

  `MSP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid right after reset")

  `MSP_ASSERT(a_hold_result, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped")

  `MSP_ASSERT(a_stall_blocks_input, out_valid_o && !out_ready_i |-> !in_ready_o,
              "request taken while result stalled")

  `MSP_ASSERT(a_idle_byte_quiet, out_valid_o && !accepted_o |-> event_res_o == EV_NONE,
              "event on unaccepted byte")

  `MSP_ASSERT(a_frame_fields_zero,
              out_valid_o && event_res_o != EV_GOOD && event_res_o != EV_CKSUM |->
                frame_version_o == 2'd0 && command_o == 16'd0 && frame_flags_o == 8'd0 &&
                payload_size_o == 8'd0 &&
                (event_res_o == EV_PAYLOAD ||
                 (payload_byte_o == 8'd0 && payload_index_o == 8'd0)),
              "stray frame fields")

endmodule

bind msp_frame_parser_core msp_frame_parser_core_chk u_chk (.*);

@@ tb/sv/msp_frame_parser_core_tb.sv @@
// Self-checking bench for msp_frame_parser_core: directed frames, then randomized
// byte streams scored against an in-bench deframer model with random stalls.
// Depends on msp_pkg and the parser RTL.
module msp_frame_parser_core_tb;
  import msp_pkg::*;

  localparam int unsigned DEAD_LIMIT  = 400;
  localparam int unsigned N_PHASES    = 8;
  localparam int unsigned PHASE_ITEMS = 80;
  localparam int unsigned N_SCRIPT    = 26;

  localparam res_t R_FREE    = '0;
  localparam res_t R_IGNORED = '{1'b0, EV_NONE, 8'h00, 8'h00, 2'd0, 16'h0000, 8'h00, 8'h00};
  localparam res_t R_NONE    = '{1'b1, EV_NONE, 8'h00, 8'h00, 2'd0, 16'h0000, 8'h00, 8'h00};
  localparam res_t R_ABANDON = '{1'b1, EV_ABANDON, 8'h00, 8'h00, 2'd0, 16'h0000, 8'h00, 8'h00};
  localparam res_t R_V21_BAD = '{1'b1, EV_CKSUM, 8'h00, 8'h00, VER_V21, 16'h0000, 8'h00, 8'h00};

  typedef struct packed {
    logic [7:0] b;
    logic       pin;
    res_t       r;
  } row_t;

  typedef struct {
    bit   pin;
    res_t r;
  } tag_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  byte_in_i   = 8'h00;
  logic        out_ready_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [7:0]  cfg_index_i = 8'h00;
  logic [7:0]  cfg_data_i  = 8'h00;
  logic        in_ready_o;
  logic        out_valid_o;
  logic        accepted_o;
  logic [2:0]  event_res_o;
  logic [7:0]  payload_byte_o;
  logic [7:0]  payload_index_o;
  logic [1:0]  frame_version_o;
  logic [15:0] command_o;
  logic [7:0]  frame_flags_o;
  logic [7:0]  payload_size_o;
  logic        cfg_ready_o;

  msp_frame_parser_core uut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .byte_in_i,
    .out_valid_o, .out_ready_i,
    .accepted_o, .event_res_o, .payload_byte_o, .payload_index_o,
    .frame_version_o, .command_o, .frame_flags_o, .payload_size_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // deframer model state
  state_e      m_state   = ST_IDLE;
  logic [7:0]  m_offs    = 8'h00;
  logic [7:0]  m_len     = 8'h00;
  logic [1:0]  m_ver     = 2'd0;
  logic [15:0] m_cmd     = 16'h0000;
  logic [7:0]  m_flags   = 8'h00;
  logic [7:0]  m_xor     = 8'h00;
  logic [7:0]  m_crc     = 8'h00;
  logic [7:0]  m_hdr [HDR_DEPTH] = '{default: 8'h00};
  logic [7:0]  m_max_len = MAX_PAYLOAD_RST;
  logic [7:0]  m_dir     = DIR_CHAR_RST;

  res_t        pending_events [$];
  tag_t        byte_tags [$];
  logic [7:0]  frame_q [$];
  logic [7:0]  gen_x, gen_c;
  int unsigned mismatches  = 0;
  int unsigned dead_cycles = 0;
  bit          quiet_in    = 1'b0;
  bit          quiet_out   = 1'b0;

  // bad second char, good v1 frame, short carrier, tunneled v2 with bad inner CRC
  row_t script [N_SCRIPT] = '{
    '{8'h00, 1'b1, R_IGNORED},
    '{8'h24, 1'b1, R_NONE}, '{8'hFF, 1'b1, R_ABANDON},
    '{8'h24, 1'b1, R_NONE}, '{8'h4D, 1'b1, R_NONE}, '{8'h3E, 1'b1, R_NONE},
    '{8'h01, 1'b1, R_NONE}, '{8'h64, 1'b1, R_NONE}, '{8'hFF, 1'b0, R_FREE},
    '{8'h9A, 1'b0, R_FREE},
    '{8'h24, 1'b1, R_NONE}, '{8'h4D, 1'b1, R_NONE}, '{8'h3E, 1'b1, R_NONE},
    '{8'h05, 1'b1, R_NONE}, '{8'hFF, 1'b1, R_ABANDON},
    '{8'h24, 1'b1, R_NONE}, '{8'h4D, 1'b1, R_NONE}, '{8'h3E, 1'b1, R_NONE},
    '{8'h06, 1'b1, R_NONE}, '{8'hFF, 1'b1, R_NONE}, '{8'h00, 1'b1, R_NONE},
    '{8'h00, 1'b1, R_NONE}, '{8'h00, 1'b1, R_NONE}, '{8'h00, 1'b1, R_NONE},
    '{8'h00, 1'b1, R_NONE}, '{8'h01, 1'b1, R_V21_BAD}
  };

  function automatic logic [7:0] crc_dvb(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] v;
    v = crc ^ b;
    repeat (8) v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
    return v;
  endfunction

  function automatic void hdr_store(input logic [7:0] c);
    if (m_offs < HDR_DEPTH) m_hdr[m_offs[HDR_AW-1:0]] = c;
    m_offs = m_offs + 8'd1;
  endfunction

  function automatic event_e take_v2_header(input logic [HDR_AW-1:0] base,
                                            input state_e pay_st, input state_e ck_st);
    logic [15:0] sz;
    sz = {m_hdr[base + 3'd4], m_hdr[base + 3'd3]};
    if (sz > {8'h00, m_max_len}) begin
      m_state = ST_IDLE;
      return EV_SIZE;
    end
    m_len   = sz[7:0];
    m_cmd   = {m_hdr[base + 3'd2], m_hdr[base + 3'd1]};
    m_flags = m_hdr[base];
    m_offs  = 8'h00;
    m_state = (m_len != 8'h00) ? pay_st : ck_st;
    return EV_NONE;
  endfunction

  function automatic res_t deframe_byte(input logic [7:0] c);
    res_t r;
    r = '0;
    r.accepted = 1'b1;
    r.ev = EV_NONE;
    case (m_state)
      ST_START: begin
        if (c == CH_M) m_state = ST_M;
        else if (c == CH_X) m_state = ST_X;
        else begin
          m_state = ST_IDLE;
          r.ev = EV_ABANDON;
        end
      end
      ST_M: begin
        if (c == m_dir) begin
          m_offs = 8'h00; m_xor = 8'h00; m_crc = 8'h00;
          m_state = ST_HDR_V1;
        end else begin
          m_state = ST_IDLE;
          r.ev = EV_ABANDON;
        end
      end
      ST_X: begin
        if (c == m_dir) begin
          m_offs = 8'h00; m_crc = 8'h00; m_ver = VER_V2N;
          m_state = ST_HDR_V2N;
        end else begin
          m_state = ST_IDLE;
          r.ev = EV_ABANDON;
        end
      end
      ST_HDR_V1: begin
        hdr_store(c);
        m_xor ^= c;
        if (m_offs >= 8'd2) begin
          if (m_hdr[0] > m_max_len) begin
            m_state = ST_IDLE;
            r.ev = EV_SIZE;
          end else if (m_hdr[1] == CMD_V2_TUNNEL) begin
            if (m_hdr[0] >= MIN_TUNNEL_SIZE) begin
              m_ver = VER_V21;
              m_state = ST_HDR_V21;
            end else begin
              m_state = ST_IDLE;
              r.ev = EV_ABANDON;
            end
          end else begin
            m_len = m_hdr[0]; m_cmd = {8'h00, m_hdr[1]}; m_flags = 8'h00; m_offs = 8'h00;
            m_state = (m_len != 8'h00) ? ST_PAY_V1 : ST_CK_V1;
          end
        end
      end
      ST_PAY_V1, ST_PAY_V21, ST_PAY_V2N: begin
        r.ev = EV_PAYLOAD;
        r.pbyte = c;
        r.pidx = m_offs;
        if (m_state != ST_PAY_V2N) m_xor ^= c;
        if (m_state != ST_PAY_V1) m_crc = crc_dvb(m_crc, c);
        m_offs = m_offs + 8'd1;
        if (m_offs == m_len) begin
          if (m_state == ST_PAY_V1) m_state = ST_CK_V1;
          else if (m_state == ST_PAY_V21) m_state = ST_CK_V21;
          else m_state = ST_CK_V2N;
        end
      end
      ST_CK_V1, ST_CK_V2N: begin
        r.ev = (((m_state == ST_CK_V1) ? m_xor : m_crc) == c) ? EV_GOOD : EV_CKSUM;
        m_state = ST_IDLE;
      end
      ST_HDR_V21: begin
        hdr_store(c);
        m_xor ^= c;
        m_crc = crc_dvb(m_crc, c);
        if (m_offs >= 8'd7) r.ev = take_v2_header(3'd2, ST_PAY_V21, ST_CK_V21);
      end
      ST_CK_V21: begin
        m_xor ^= c;
        if (m_crc == c) m_state = ST_CK_V1;
        else begin
          m_state = ST_IDLE;
          r.ev = EV_CKSUM;
        end
      end
      ST_HDR_V2N: begin
        hdr_store(c);
        m_crc = crc_dvb(m_crc, c);
        if (m_offs >= 8'd5) r.ev = take_v2_header(3'd0, ST_PAY_V2N, ST_CK_V2N);
      end
      default: begin
        m_state = ST_IDLE;
        if (c == CH_DOLLAR) begin
          m_ver = VER_V1;
          m_state = ST_START;
        end else r.accepted = 1'b0;
      end
    endcase
    if (r.ev == EV_GOOD || r.ev == EV_CKSUM) begin
      r.version = m_ver;
      r.command = m_cmd;
      r.flags   = m_flags;
      r.size    = m_len;
    end
    return r;
  endfunction

  function automatic void cmp_field(input string f, input logic [15:0] e, input logic [15:0] a);
    if (a !== e) begin
      mismatches++;
      $display("%0t %s: expected %0h actual %0h", $time, f, e, a);
    end
  endfunction

  always @(posedge clk_i) begin : score
    res_t want;
    tag_t t;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_MAX_PAYLOAD) m_max_len = cfg_data_i;
        else if (cfg_index_i == CFG_DIR_CHAR) m_dir = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        t = byte_tags.pop_front();
        want = deframe_byte(byte_in_i);
        if (t.pin) want = t.r;
        pending_events.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_events.size() == 0) begin
          mismatches++;
          $display("%0t unexpected result: event %0d", $time, event_res_o);
        end else begin
          want = pending_events.pop_front();
          cmp_field("accepted", 16'(want.accepted), 16'(accepted_o));
          cmp_field("event", 16'(want.ev), 16'(event_res_o));
          cmp_field("payload_byte", 16'(want.pbyte), 16'(payload_byte_o));
          cmp_field("payload_index", 16'(want.pidx), 16'(payload_index_o));
          cmp_field("frame_version", 16'(want.version), 16'(frame_version_o));
          cmp_field("command", want.command, command_o);
          cmp_field("frame_flags", 16'(want.flags), 16'(frame_flags_o));
          cmp_field("payload_size", 16'(want.size), 16'(payload_size_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      dead_cycles <= 0;
    else
      dead_cycles <= dead_cycles + 1;
    if (dead_cycles == DEAD_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result taker: random stall per result
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = quiet_out ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] spoil(input int unsigned odds);
    return ($urandom_range(1, odds) == 1) ? 8'($urandom_range(1, 255)) : 8'h00;
  endfunction

  function automatic logic [7:0] pick_len(input logic [7:0] mp);
    int unsigned r;
    r = $urandom_range(0, 29);
    if (r == 0) return mp;
    if (r == 1) return 8'($urandom_range(0, mp));
    return 8'($urandom_range(0, (mp < 8'd8) ? mp : 8));
  endfunction

  function automatic void emit(input logic [7:0] b);
    frame_q.push_back(b);
    gen_x ^= b;
    gen_c = crc_dvb(gen_c, b);
  endfunction

  function automatic void open_frame(input logic [7:0] lead, input logic [7:0] dch);
    emit(CH_DOLLAR);
    emit(lead);
    emit(dch);
    gen_x = 8'h00;
    gen_c = 8'h00;
  endfunction

  function automatic void build_frame(input logic [7:0] mp, input logic [7:0] dch);
    int unsigned kind;
    logic [7:0]  s, o;
    logic [15:0] cmd16, big, sz16;
    frame_q.delete();
    kind  = $urandom_range(0, 99);
    cmd16 = 16'($urandom_range(0, 65535));
    big   = 16'($urandom_range(int'(mp) + 1, 65535));
    s     = pick_len(mp);
    if (kind >= 55 && kind < 75 && mp < MIN_TUNNEL_SIZE) kind = 0;
    if (kind < 30) begin
      open_frame(CH_M, dch);
      emit(s);
      emit(8'($urandom_range(0, 254)));
      repeat (s) emit(rnd8());
      emit(gen_x ^ spoil(8));
    end else if (kind < 55) begin
      open_frame(CH_X, dch);
      emit(rnd8()); emit(cmd16[7:0]); emit(cmd16[15:8]); emit(s); emit(8'h00);
      repeat (s) emit(rnd8());
      emit(gen_c ^ spoil(8));
    end else if (kind < 75) begin
      o = 8'($urandom_range(MIN_TUNNEL_SIZE, (mp < 8'd16) ? mp : 16));
      sz16 = ($urandom_range(0, 9) == 0) ? big : {8'h00, s};
      open_frame(CH_M, dch);
      emit(o);
      emit(CMD_V2_TUNNEL);
      gen_c = 8'h00;
      emit(rnd8()); emit(cmd16[7:0]); emit(cmd16[15:8]); emit(sz16[7:0]); emit(sz16[15:8]);
      if (sz16 == {8'h00, s}) begin
        repeat (s) emit(rnd8());
        emit(gen_c ^ spoil(10));
        emit(gen_x ^ spoil(10));
      end
    end else if (kind < 85) begin
      if (mp != 8'hFF && $urandom_range(0, 1) == 0) begin
        open_frame(CH_M, dch);
        emit(8'($urandom_range(int'(mp) + 1, 255)));
        emit(rnd8());
      end else begin
        open_frame(CH_X, dch);
        repeat (3) emit(rnd8());
        emit(big[7:0]);
        emit(big[15:8]);
      end
    end else if (kind < 90) begin
      open_frame(CH_M, dch);
      emit(8'($urandom_range(0, 5)));
      emit(CMD_V2_TUNNEL);
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          emit(CH_DOLLAR);
          emit(rnd8());
        end
        1: begin
          emit(CH_DOLLAR);
          emit(($urandom_range(0, 1) == 0) ? CH_M : CH_X);
          emit(rnd8());
        end
        default: repeat ($urandom_range(1, 6)) emit(rnd8());
      endcase
    end
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit pin, input res_t r);
    int unsigned gap;
    tag_t t;
    gap = quiet_in ? 0 : $urandom_range(0, 12);
    t.pin = pin;
    t.r = r;
    byte_tags.push_back(t);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0]  mp, dch;
    int unsigned sent;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) send_byte(script[i].b, script[i].pin, script[i].r);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin mp = MAX_PAYLOAD_RST; dch = DIR_CHAR_RST; end
        1: begin mp = 8'hFF; dch = DIR_CHAR_RST; end
        2: begin mp = 8'h00; dch = 8'h3C; end
        3: begin mp = 8'($urandom_range(6, 40)); dch = 8'h00; end
        4: begin mp = MIN_TUNNEL_SIZE; dch = 8'hFF; end
        5: begin mp = rnd8(); dch = rnd8(); end
        6: begin mp = 8'hFF; dch = CH_DOLLAR; end
        default: begin mp = 8'($urandom_range(0, 20)); dch = CH_M; end
      endcase
      write_reg(CFG_MAX_PAYLOAD, mp);
      write_reg(CFG_DIR_CHAR, dch);
      if ($urandom_range(0, 2) == 0)
        write_reg(8'($urandom_range(int'(CFG_DIR_CHAR) + 1, 255)), rnd8());
      cfg_valid_i <= 1'b0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 15) == 0) quiet_in = !quiet_in;
        if ($urandom_range(0, 15) == 0) quiet_out = !quiet_out;
        build_frame(mp, dch);
        foreach (frame_q[i]) send_byte(frame_q[i], 1'b0, R_FREE);
        sent += frame_q.size();
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) send_byte(rnd8(), 1'b0, R_FREE);
      end
    end

    drain_results();
    if (mismatches == 0 && pending_events.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/msp_pkg.sv
rtl/msp_parse.sv
rtl/msp_frame_parser_core.sv
rtl/msp_frame_parser_core_chk.sv
tb/sv/msp_frame_parser_core_tb.sv
